@@ src/hee_pkg.sv @@
// Shared types, constants and entity tables for the HTML entity escaper.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hee_pkg;

  // Width of the written and required byte counters.
  localparam int COUNT_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int REQ_W      = 16;
  localparam int SUM_W      = ((COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W) + 1;
  localparam int CFG_RESET  = 100;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [REQ_W-1:0]      REQ_MAX = '1;

  typedef logic [2:0] ent_idx_t;
  typedef logic [2:0] ent_pos_t;

  localparam ent_idx_t ENT_QUOT = 3'd0;
  localparam ent_idx_t ENT_APOS = 3'd1;
  localparam ent_idx_t ENT_AMP  = 3'd2;
  localparam ent_idx_t ENT_LT   = 3'd3;
  localparam ent_idx_t ENT_GT   = 3'd4;
  localparam ent_idx_t ENT_NBSP = 3'd5;

  typedef enum logic [1:0] {
    CMD_CHAR   = 2'd0,
    CMD_ENT    = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_kind_t;

  // One queued piece of work: a plain byte, an entity or the end report.
  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;   // byte, or entity index in the low bits
    logic [REQ_W-1:0] req;
    logic             trunc;
  } cmd_t;

  function automatic ent_pos_t ent_len(input ent_idx_t idx);
    ent_pos_t len;
    case (idx)
      ENT_AMP:         len = 3'd5;
      ENT_LT, ENT_GT:  len = 3'd4;
      default:         len = 3'd6;
    endcase
    return len;
  endfunction

  // Entity text, left-justified, first character in the top byte.
  function automatic logic [7:0] ent_byte(input ent_idx_t idx, input ent_pos_t pos);
    logic [47:0] txt;
    case (idx)
      ENT_QUOT: txt = "&quot;";
      ENT_APOS: txt = "&apos;";
      ENT_AMP:  txt = {"&amp;", 8'h00};
      ENT_LT:   txt = {"&lt;", 16'h0000};
      ENT_GT:   txt = {"&gt;", 16'h0000};
      default:  txt = "&nbsp;";
    endcase
    return txt[47 - 8 * pos -: 8];
  endfunction

endpackage

`default_nettype wire

@@ src/hee_front.sv @@
// Front end: accepts input transactions, classifies bytes, keeps the counters
// and the stop flag, and pushes work into the queue. Depends on hee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hee_front (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire  [hee_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire                             item_valid,
  input  wire  [7:0]                      item_byte,
  input  wire                             item_end,
  input  wire                             q_full,
  output logic                            item_ready,
  output logic                            q_push,
  output hee_pkg::cmd_t                   q_wdata
);
  import hee_pkg::*;

  logic [CFG_W-1:0]      buf_size_r;
  logic [COUNT_BITS-1:0] written_r, written_nxt;
  logic [COUNT_BITS-1:0] required_r, required_nxt;
  logic                  stopped_r, stopped_nxt;

  logic                  is_meta;
  ent_idx_t              idx;
  ent_pos_t              len;
  logic [CFG_W-1:0]      limit;
  logic [SUM_W-1:0]      wr_sum, req_sum, rep_sum;
  logic                  fits;
  logic                  accept;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;

  always_comb begin
    is_meta = 1'b1;
    unique case (item_byte)
      8'h22:   idx = ENT_QUOT;
      8'h27:   idx = ENT_APOS;
      8'h26:   idx = ENT_AMP;
      8'h3C:   idx = ENT_LT;
      8'h3E:   idx = ENT_GT;
      8'h20:   idx = ENT_NBSP;
      default: begin
        idx     = ENT_QUOT;
        is_meta = 1'b0;
      end
    endcase
    len = is_meta ? ent_len(idx) : 3'd1;
  end

  always_comb begin
    // One byte is kept back for the terminator; a zero size acts like one.
    limit   = (buf_size_r == '0) ? '0 : buf_size_r - 1'b1;
    wr_sum  = SUM_W'(written_r) + SUM_W'(len);
    req_sum = SUM_W'(required_r) + SUM_W'(len);
    rep_sum = SUM_W'(required_r) + SUM_W'(1);
    fits    = (wr_sum <= SUM_W'(limit)) && (wr_sum <= SUM_W'(CNT_MAX));
  end

  always_comb begin
    written_nxt  = written_r;
    required_nxt = required_r;
    stopped_nxt  = stopped_r;
    q_push       = 1'b0;
    q_wdata      = '{kind: CMD_CHAR, data: item_byte, req: '0, trunc: 1'b0};
    if (accept) begin
      if (item_end) begin
        q_push       = 1'b1;
        q_wdata.kind = CMD_REPORT;
        q_wdata.data = '0;
        q_wdata.req  = (rep_sum > SUM_W'(REQ_MAX)) ? REQ_MAX : rep_sum[REQ_W-1:0];
        q_wdata.trunc = stopped_r;
        written_nxt  = '0;
        required_nxt = '0;
        stopped_nxt  = 1'b0;
      end else begin
        required_nxt = (req_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : req_sum[COUNT_BITS-1:0];
        if (!stopped_r) begin
          if (fits) begin
            q_push      = 1'b1;
            written_nxt = wr_sum[COUNT_BITS-1:0];
            if (is_meta) begin
              q_wdata.kind = CMD_ENT;
              q_wdata.data = 8'(idx);
            end
          end else begin
            stopped_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= CFG_W'(CFG_RESET);
      written_r  <= '0;
      required_r <= '0;
      stopped_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        buf_size_r <= cfg_wdata;
      end
      written_r  <= written_nxt;
      required_r <= required_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/hee_queue.sv @@
// Short show-ahead queue of work commands between front and back end.
// Depends on hee_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module hee_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  hee_pkg::cmd_t  wdata,
  input  wire            pop,
  output logic           full,
  output logic           empty,
  output hee_pkg::cmd_t  rdata
);
  import hee_pkg::*;

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, rptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/hee_back.sv @@
// Back end: expands queued commands into output bytes, one per cycle unless
// out_ready stalls, and holds them in the output register. Depends on hee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hee_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          q_empty,
  input  hee_pkg::cmd_t                q_rdata,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [7:0]                   out_byte,
  output logic                         out_last,
  output logic                         out_report,
  output logic [hee_pkg::REQ_W-1:0]    out_req,
  output logic                         out_trunc
);
  import hee_pkg::*;

  ent_pos_t         pos_r;
  logic             valid_r;
  logic [7:0]       byte_r;
  logic             last_r, report_r, trunc_r;
  logic [REQ_W-1:0] req_r;

  logic             load;
  logic [7:0]       byte_nxt;
  logic             last_nxt;
  ent_idx_t         idx;

  assign idx  = q_rdata.data[2:0];
  assign load = !q_empty && (!valid_r || out_ready);

  always_comb begin
    unique case (q_rdata.kind)
      CMD_ENT: begin
        byte_nxt = ent_byte(idx, pos_r);
        last_nxt = (pos_r == ent_len(idx) - 3'd1);
      end
      CMD_REPORT: begin
        byte_nxt = '0;
        last_nxt = 1'b1;
      end
      default: begin
        byte_nxt = q_rdata.data;
        last_nxt = 1'b1;
      end
    endcase
  end

  // The head command leaves the queue with its last byte.
  assign q_pop = load && last_nxt;

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= byte_nxt;
      last_r   <= last_nxt;
      report_r <= (q_rdata.kind == CMD_REPORT);
      req_r    <= (q_rdata.kind == CMD_REPORT) ? q_rdata.req : '0;
      trunc_r  <= (q_rdata.kind == CMD_REPORT) && q_rdata.trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        pos_r   <= last_nxt ? '0 : pos_r + 3'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = valid_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;
  assign out_report = report_r;
  assign out_req    = req_r;
  assign out_trunc  = trunc_r;

endmodule

`default_nettype wire

@@ src/html_entity_escaper_unit.sv @@
// Top level of the HTML entity escaper: front end, command queue, back end.
// Depends on hee_pkg, hee_front, hee_queue and hee_back.
`timescale 1ns / 1ps
`default_nettype none

// Escapes a byte stream into HTML entities. Each input transaction carries one
// byte, or with in_tlast high asks for the end report (terminator zero, full
// escaped size plus one, truncation flag), after which the counts restart.
// The output channel moves one byte per cycle unless out_tready stalls it
// (an entity gives four to six); the back-end expander sets this rate.
// Input is taken every cycle while the four-entry command queue has room,
// so input and output stall independently. Output stops once a piece would
// not fit in buffer_size minus one, but counting continues. buffer_size resets
// to 100; the user writes it through the cfg channel while idle (unenforced).
module html_entity_escaper_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [hee_pkg::CFG_W-1:0]        cfg_data,       // buffer_size
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [hee_pkg::IN_DATA_W-1:0]    in_tdata,       // [7:0] in_byte
  input  wire                              in_tlast,       // end_of_text
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [7:0] out_byte, [23:8] required_size, [24] truncated, [31:25] zero
  output logic [hee_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast,      // run_last
  output logic                             out_tuser       // is_report
);
  import hee_pkg::*;

  logic             q_push, q_pop, q_full, q_empty;
  cmd_t             q_wdata, q_rdata;
  logic [7:0]       o_byte;
  logic [REQ_W-1:0] o_req;
  logic             o_trunc;

  assign cfg_ready = 1'b1;

  hee_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_wdata  (cfg_data),
    .item_valid (in_tvalid),
    .item_byte  (in_tdata[7:0]),
    .item_end   (in_tlast),
    .q_full     (q_full),
    .item_ready (in_tready),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  hee_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  hee_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (o_byte),
    .out_last   (out_tlast),
    .out_report (out_tuser),
    .out_req    (o_req),
    .out_trunc  (o_trunc)
  );

  assign out_tdata = {7'd0, o_trunc, o_req, o_byte};

endmodule

`default_nettype wire
